// ===== sv/uart_tx_with_fifo_assert.svh =====
// Assertion macros shared by the serial transmitter modules
`ifndef UART_TX_WITH_FIFO_ASSERT_SVH
`define UART_TX_WITH_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
`define UTXF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UTXF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTXF_ASSERT(lbl, clk, rstn, prop, msg)
`define UTXF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/utxf_pkg.sv =====
// Types and constants shared by the serial transmitter modules
package utxf_pkg;

    localparam int FRAME_BITS = 8;
    localparam int BIT_CNT_W  = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PUT   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    typedef struct packed {
        logic line;
        logic done;
        logic active;
        logic dropped;
    } tx_status_t;

endpackage

// ===== sv/utxf_fifo.sv =====
// Byte FIFO with registered read port and fill count
module utxf_fifo #(
    parameter int  DEPTH = 16,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  utxf_pkg::fifo_ctrl_t  ctrl,
    input  logic [7:0]            wr_data,
    output logic [7:0]            rd_data,
    output utxf_pkg::fifo_stat_t  stat,
    output logic [CNT_W-1:0]      count_next
);

`include "uart_tx_with_fifo_assert.svh"

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign rd_data    = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (ctrl.pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    `UTXF_ASSERT(a_no_push_pop, aclk, aresetn,
        !(ctrl.push && ctrl.pop), "push and pop together")
    `UTXF_ASSERT(a_pop_nonempty, aclk, aresetn,
        ctrl.pop |-> !stat.empty, "pop from empty FIFO")
    `UTXF_ASSERT(a_push_notfull, aclk, aresetn,
        ctrl.push |-> !stat.full, "push to full FIFO")
    `UTXF_ASSERT(a_count_up, aclk, aresetn,
        ctrl.push |=> count_reg == CNT_W'($past(count_reg) + 1'b1), "count did not advance on push")
    `UTXF_ASSERT(a_count_range, aclk, aresetn,
        count_reg <= CNT_W'(DEPTH), "fill count beyond depth")

endmodule

// ===== sv/utxf_engine.sv =====
// Frame sequencer: start, eight data bits LSB first, stop; busy and complete flags
module utxf_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  utxf_pkg::op_t         op,
    input  utxf_pkg::fifo_stat_t  fifo_stat,
    input  logic [7:0]            rd_data,
    output utxf_pkg::fifo_ctrl_t  fifo_ctrl,
    output utxf_pkg::tx_status_t  status
);

`include "uart_tx_with_fifo_assert.svh"

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [utxf_pkg::BIT_CNT_W-1:0]   bits_reg, bits_next;
    logic [7:0]                       shift_reg, shift_next;
    logic                             line_reg, line_next;
    logic                             done_reg, done_next;
    logic                             active_reg, active_next;
    logic                             dropped;

    always_comb begin
        phase_next     = phase_reg;
        bits_next      = bits_reg;
        shift_next     = shift_reg;
        line_next      = line_reg;
        done_next      = done_reg;
        active_next    = active_reg;
        dropped        = 1'b0;
        fifo_ctrl.push = 1'b0;
        fifo_ctrl.pop  = 1'b0;
        if (accept) begin
            case (op)
                utxf_pkg::OP_TICK: begin
                    if (active_reg) begin
                        case (phase_reg)
                            PH_IDLE: begin
                                if (!fifo_stat.empty) begin
                                    done_next     = 1'b0;
                                    bits_next     = '0;
                                    phase_next    = PH_START;
                                    fifo_ctrl.pop = 1'b1;
                                end else begin
                                    active_next = 1'b0;
                                    done_next   = 1'b1;
                                end
                            end
                            PH_START: begin
                                line_next  = 1'b0;
                                shift_next = rd_data;
                                phase_next = PH_DATA;
                            end
                            PH_DATA: begin
                                line_next  = shift_reg[0];
                                shift_next = {1'b0, shift_reg[7:1]};
                                bits_next  = bits_reg + 1'b1;
                                if (bits_reg ==
                                    utxf_pkg::BIT_CNT_W'(utxf_pkg::FRAME_BITS - 1)) begin
                                    bits_next  = '0;
                                    phase_next = PH_STOP;
                                end
                            end
                            default: begin
                                line_next  = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                utxf_pkg::OP_PUT: begin
                    fifo_ctrl.push = !fifo_stat.full;
                    dropped        = fifo_stat.full;
                    active_next    = 1'b1;
                end
                utxf_pkg::OP_CLEAR: begin
                    done_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign status.line    = line_next;
    assign status.done    = done_next;
    assign status.active  = active_next;
    assign status.dropped = dropped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            bits_reg   <= '0;
            line_reg   <= 1'b1;
            done_reg   <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            bits_reg   <= bits_next;
            line_reg   <= line_next;
            done_reg   <= done_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    `UTXF_ASSERT(a_busy_in_frame, aclk, aresetn, (phase_reg != PH_IDLE) |-> active_reg, "frame in progress while not busy")
    `UTXF_ASSERT(a_pop_starts, aclk, aresetn, fifo_ctrl.pop |=> (phase_reg == PH_START), "pop did not start a frame")
    `UTXF_ASSERT(a_line_idle, aclk, aresetn, (phase_reg == PH_IDLE || phase_reg == PH_START) |-> line_reg, "line low outside frame bits")
    `UTXF_ASSERT(a_done_not_busy, aclk, aresetn, (done_reg && phase_reg != PH_IDLE) |-> 1'b0, "complete flag set mid-frame")

endmodule

// ===== sv/uart_tx_with_fifo.sv =====
// 8N1 serial transmitter with byte FIFO, top level
// Takes one transaction per clock: a byte put, a bit-time tick or a clear of the
// complete flag, selected by s_tuser. Each transaction yields one status
// transaction on the m_ side in the next cycle, from an output register; the input
// stalls only while that register holds a result not yet taken. The FIFO keeps
// FIFO_DEPTH bytes in a memory with one write and one registered read port;
// the popped byte is read on the idle tick and enters the shift register on
// the start-bit tick. No clearing pass is needed after reset.
module uart_tx_with_fifo #(
    parameter int  FIFO_DEPTH = 16,
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1),
    localparam int M_W        = ((4 + CNT_W + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] data_byte
    input  logic [1:0]      s_tuser,   // [1:0] operation
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [M_W-1:0]  m_tdata    // [0] line_level, [1] complete_flag, [2] busy_res,
                                       // [3] dropped, [4 +: CNT_W] queued_count
);

    logic                  accept;
    utxf_pkg::fifo_ctrl_t  fifo_ctrl;
    utxf_pkg::fifo_stat_t  fifo_stat;
    utxf_pkg::tx_status_t  status;
    logic [7:0]            rd_data;
    logic [CNT_W-1:0]      count_next;
    logic [M_W-1:0]        result;
    logic                  m_valid_reg;
    logic [M_W-1:0]        m_tdata_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    utxf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (fifo_ctrl),
        .wr_data    (s_tdata),
        .rd_data    (rd_data),
        .stat       (fifo_stat),
        .count_next (count_next)
    );

    utxf_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (utxf_pkg::op_t'(s_tuser)),
        .fifo_stat (fifo_stat),
        .rd_data   (rd_data),
        .fifo_ctrl (fifo_ctrl),
        .status    (status)
    );

    always_comb begin
        result              = '0;
        result[0]           = status.line;
        result[1]           = status.done;
        result[2]           = status.active;
        result[3]           = status.dropped;
        result[4 +: CNT_W]  = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/tb_uart_tx_with_fifo.sv =====
// Self-checking testbench for the FIFO-fed 8N1 serial transmitter with status stream
module tb_uart_tx_with_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int M_W        = ((4 + CNT_W + 7) / 8) * 8;
    localparam int STALL_MAX  = 2000;
    localparam int ITEM_GOAL  = 1750;
    localparam int PRINT_MAX  = 50;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } line_phase_t;

    typedef struct packed {
        logic [M_W-5-CNT_W:0] pad;
        logic [CNT_W-1:0]     count;
        logic                 dropped;
        logic                 busy;
        logic                 done;
        logic                 line;
    } tx_status_word_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        bit         drain;
    } tx_item_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata  = 8'h00;
    logic [1:0]     s_tuser  = utxf_pkg::OP_TICK;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    tx_item_t        pending[$];
    tx_status_word_t status_due[$];

    logic            s_taken   = 1'b0;
    logic            m_taken   = 1'b0;
    int              put_gap   = 0;
    int              take_gap  = 0;
    bit              s_rush    = 1'b0;
    bit              m_rush    = 1'b0;
    int              quiet     = 0;
    int              mismatches = 0;

    logic [7:0]       q_mem[FIFO_DEPTH];
    logic [PTR_W-1:0] q_rd     = '0;
    logic [PTR_W-1:0] q_wr     = '0;
    logic [CNT_W-1:0] q_fill   = '0;
    line_phase_t      q_phase  = PH_IDLE;
    logic [7:0]       q_shift  = 8'h00;
    logic [2:0]       q_nbits  = 3'd0;
    logic             q_line   = 1'b1;
    logic             q_done   = 1'b0;
    logic             q_active = 1'b0;

    uart_tx_with_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap(input bit rush);
        return rush ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic tx_status_word_t advance_transmitter(input logic [1:0] op,
                                                            input logic [7:0] din);
        tx_status_word_t st;
        logic            lost;
        lost = 1'b0;
        case (op)
            utxf_pkg::OP_TICK: begin
                if (q_active) begin
                    case (q_phase)
                        PH_IDLE: begin
                            if (q_fill != 0) begin
                                q_done  = 1'b0;
                                q_nbits = 3'd0;
                                q_shift = q_mem[q_rd];
                                q_rd    = (q_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : q_rd + 1'b1;
                                q_fill  = q_fill - 1'b1;
                                q_phase = PH_START;
                            end else begin
                                q_active = 1'b0;
                                q_done   = 1'b1;
                            end
                        end
                        PH_START: begin
                            q_line  = 1'b0;
                            q_phase = PH_DATA;
                        end
                        PH_DATA: begin
                            q_line  = q_shift[0];
                            q_shift = q_shift >> 1;
                            if (q_nbits == 3'd7) begin
                                q_nbits = 3'd0;
                                q_phase = PH_STOP;
                            end else begin
                                q_nbits = q_nbits + 1'b1;
                            end
                        end
                        default: begin
                            q_line  = 1'b1;
                            q_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            utxf_pkg::OP_PUT: begin
                if (q_fill < CNT_W'(FIFO_DEPTH)) begin
                    q_mem[q_wr] = din;
                    q_wr        = (q_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : q_wr + 1'b1;
                    q_fill      = q_fill + 1'b1;
                end else begin
                    lost = 1'b1;
                end
                q_active = 1'b1;
            end
            utxf_pkg::OP_CLEAR: q_done = 1'b0;
            default: ;
        endcase
        st         = '0;
        st.line    = q_line;
        st.done    = q_done;
        st.busy    = q_active;
        st.dropped = lost;
        st.count   = q_fill;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("%0t: %s mismatch, got %0d, want %0d", $realtime, what, got, want);
    endtask

    task automatic add_item(input logic [1:0] op, input logic [7:0] data, input bit drain,
                            ref int n_items);
        tx_item_t it;
        it.op    = op;
        it.data  = data;
        it.drain = drain;
        pending.push_back(it);
        if (op != OP_SPARE)
            n_items++;
    endtask

    always @(negedge aclk) begin
        tx_item_t nxt;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (put_gap != 0) begin
                put_gap  <= put_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0 &&
                         (!pending[0].drain || status_due.size() == 0)) begin
                nxt = pending.pop_front();
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.data;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    s_rush = !s_rush;
                put_gap <= pick_gap(s_rush);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        int stall;
        if (aresetn) begin
            stall = take_gap;
            if (m_taken) begin
                if ($urandom_range(0, 39) == 0)
                    m_rush = !m_rush;
                stall = pick_gap(m_rush);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                take_gap <= stall - 1;
            end else begin
                m_tready <= 1'b1;
                take_gap <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        tx_status_word_t got;
        tx_status_word_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        m_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = tx_status_word_t'(m_tdata);
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected transaction, status word", int'(m_tdata), 0);
                end else begin
                    want = status_due.pop_front();
                    if (got.line !== want.line)
                        report_mismatch("line_level", int'(got.line), int'(want.line));
                    if (got.done !== want.done)
                        report_mismatch("complete_flag", int'(got.done), int'(want.done));
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", int'(got.busy), int'(want.busy));
                    if (got.dropped !== want.dropped)
                        report_mismatch("dropped", int'(got.dropped), int'(want.dropped));
                    if (got.count !== want.count)
                        report_mismatch("queued_count", int'(got.count), int'(want.count));
                    if (got.pad !== want.pad)
                        report_mismatch("padding", int'(got.pad), int'(want.pad));
                end
            end
            if (s_tvalid && s_tready)
                status_due.push_back(advance_transmitter(s_tuser, s_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_MAX) begin
                $display("tb_uart_tx_with_fifo NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int n_items;
        int n_put;
        int owed;
        int n_tick;
        int seq;
        int pick;
        n_items = 0;
        owed    = 0;
        seq     = 0;

        add_item(utxf_pkg::OP_TICK, 8'h00, 1'b0, n_items);
        add_item(OP_SPARE, 8'hFF, 1'b0, n_items);
        add_item(utxf_pkg::OP_CLEAR, 8'h00, 1'b0, n_items);
        add_item(utxf_pkg::OP_PUT, 8'hFF, 1'b0, n_items);
        add_item(utxf_pkg::OP_PUT, 8'h00, 1'b0, n_items);
        for (int i = 0; i < FIFO_DEPTH - 2; i++)
            add_item(utxf_pkg::OP_PUT, 8'($urandom), 1'b0, n_items);
        add_item(utxf_pkg::OP_PUT, 8'h5A, 1'b0, n_items);
        add_item(utxf_pkg::OP_CLEAR, 8'h00, 1'b0, n_items);
        add_item(OP_SPARE, 8'h00, 1'b0, n_items);
        owed = FIFO_DEPTH;

        while (n_items < ITEM_GOAL) begin
            seq++;
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                n_put = $urandom_range(1, 4);
                for (int i = 0; i < n_put; i++) begin
                    add_item(utxf_pkg::OP_PUT, 8'($urandom), (i == 0) && (seq % 10 == 0),
                             n_items);
                    if (owed < FIFO_DEPTH + 1)
                        owed++;
                end
                n_tick = owed * 11 + $urandom_range(1, 4);
                owed   = 0;
                for (int i = 0; i < n_tick; i++) begin
                    add_item(utxf_pkg::OP_TICK, 8'($urandom), 1'b0, n_items);
                    case ($urandom_range(0, 59))
                        0, 1, 2: add_item(utxf_pkg::OP_CLEAR, 8'($urandom), 1'b0, n_items);
                        3, 4: begin
                            add_item(utxf_pkg::OP_PUT, 8'($urandom), 1'b0, n_items);
                            owed++;
                        end
                        5: add_item(OP_SPARE, 8'($urandom), 1'b0, n_items);
                        default: ;
                    endcase
                end
                if ($urandom_range(0, 1) == 0)
                    add_item(utxf_pkg::OP_CLEAR, 8'($urandom), 1'b0, n_items);
            end else if (pick < 18) begin
                n_put = $urandom_range(5, 20);
                for (int i = 0; i < n_put; i++) begin
                    add_item(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, n_items);
                    if (pending[$].op == utxf_pkg::OP_PUT && owed < FIFO_DEPTH + 1)
                        owed++;
                end
            end else begin
                n_put = $urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 4);
                for (int i = 0; i < n_put; i++)
                    add_item(utxf_pkg::OP_PUT, 8'($urandom), i == 0, n_items);
                owed = FIFO_DEPTH + 1;
            end
        end

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid || status_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("tb_uart_tx_with_fifo OK");
        else
            $display("tb_uart_tx_with_fifo NOT OK");
        $finish;
    end

endmodule
